@@ src/hsvm_pkg.sv @@
`default_nettype none
package hsvm_pkg;
  localparam int FracBits = 16;
  localparam logic [16:0] One = 17'h10000;
  localparam logic [31:0] MarkColor = 32'h800080FF;
  localparam logic [2:0] RegHueLow = 3'd0;
  localparam logic [2:0] RegHueHigh = 3'd1;
  localparam logic [2:0] RegSatLow = 3'd2;
  localparam logic [2:0] RegSatHigh = 3'd3;
  localparam logic [2:0] RegValLow = 3'd4;
  localparam logic [2:0] RegValHigh = 3'd5;

  // Multiplier for a divide by six: ceil(2^22 / 6), used with a 22-bit shift.
  localparam logic [19:0] Div6Mul = 20'd699051;

  // Floor of 2^32 over every divisor from 2 to 255, 32 bits per entry.
  // Divisors 0 and 1 read all ones, one below the true value for 1.
  function automatic logic [8191:0] build_recip();
    logic [8191:0] tab;
    tab = '1;
    for (int i = 2; i < 256; i++) begin
      tab[i*32 +: 32] = 32'(64'h100000000 / 64'(i));
    end
    return tab;
  endfunction

  localparam logic [8191:0] RecipTab = build_recip();
endpackage
`default_nettype wire

@@ src/hsvm_div.sv @@
`default_nettype none
// Pipelined 27-bit by 8-bit divide with a remainder fix-up; three register stages.
module hsvm_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [26:0] num,
  input  wire logic [7:0]  den,
  output logic      [18:0] quo
);
  logic [26:0] num_r, num2_r;
  logic [7:0] den_r, den2_r;
  logic [31:0] rcp_r;
  logic [58:0] prod_r;
  logic [18:0] quo_r;
  logic [26:0] q_est;
  logic [34:0] back;
  logic [34:0] rem;
  logic [7:0] den_safe;

  // The reciprocal rounds down, so the estimate is the quotient or one below it.
  assign den_safe = (den == 8'd0) ? 8'd1 : den;
  assign q_est = prod_r[58:32];
  assign back = {8'd0, q_est} * {27'd0, den2_r};
  assign rem = {8'd0, num2_r} - back;

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num;
      den_r <= den_safe;
      rcp_r <= hsvm_pkg::RecipTab[{den_safe, 5'd0} +: 32];
      prod_r <= {32'd0, num_r} * {27'd0, rcp_r};
      num2_r <= num_r;
      den2_r <= den_r;
      if (rem >= {27'd0, den2_r}) begin
        quo_r <= q_est[18:0] + 19'd1;
      end else begin
        quo_r <= q_est[18:0];
      end
    end
  end
  assign quo = quo_r;
endmodule
`default_nettype wire

@@ src/hsv_range_pixel_mask.sv @@
`default_nettype none
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_pixel_in
// out     | output    | out_valid, out_ready, out_pixel_out, out_marked, out_hue,
//         |           | out_saturation, out_brightness
// cfg     | input     | cfg_we, cfg_index, cfg_data
// One item per clock while out_ready does not hold the pipe; six register
// stages. The depth is set by the max and min stage, then the divide units
// (reciprocal lookup, multiply, fix-up), then the hue multiply by one sixth,
// then the bound compare. A result waits in the output register until taken.
// The whole pipeline advances together; when out_ready is low and the last
// stage is full, every stage holds, so nothing is lost or repeated.
// Reset loads the low bounds with 1.0 and the high bounds with 0, so no pixel
// is marked until the bounds are written.
module hsv_range_pixel_mask (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_pixel_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] out_pixel_out,
  output logic             out_marked,
  output logic      [15:0] out_hue,
  output logic      [16:0] out_saturation,
  output logic      [16:0] out_brightness,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);
  logic [16:0] hue_low_r, hue_high_r, sat_low_r, sat_high_r, val_low_r, val_high_r;
  logic [5:0] vld_r;
  logic en;
  logic [31:0] px_r [5];
  logic [7:0] mx_r;
  logic [7:0] d_r;
  logic [10:0] hnum_r;
  logic gray_r [5];
  logic [16:0] v_r [5];
  logic [16:0] s4_r;
  logic [38:0] h6_r;
  logic [31:0] pxo_r;
  logic mk_r;
  logic [15:0] h_r;
  logic [16:0] s_r, vo_r;

  // Stall the whole pipe only when the last stage holds an untaken result.
  assign en = !vld_r[5] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r <= hsvm_pkg::One; sat_low_r <= hsvm_pkg::One; val_low_r <= hsvm_pkg::One;
      hue_high_r <= '0; sat_high_r <= '0; val_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hsvm_pkg::RegHueLow:  hue_low_r <= cfg_data;
        hsvm_pkg::RegHueHigh: hue_high_r <= cfg_data;
        hsvm_pkg::RegSatLow:  sat_low_r <= cfg_data;
        hsvm_pkg::RegSatHigh: sat_high_r <= cfg_data;
        hsvm_pkg::RegValLow:  val_low_r <= cfg_data;
        hsvm_pkg::RegValHigh: val_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  // Stage 0: max, min and the hue sector numerator, with 6d added when negative.
  logic [7:0] r, g, b, mx, mn, d;
  logic [10:0] hn;
  always_comb begin
    r = in_pixel_in[7:0]; g = in_pixel_in[15:8]; b = in_pixel_in[23:16];
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    d = mx - mn;
    if (r == mx) begin
      hn = (g >= b) ? {3'd0, g - b} : 11'({3'd0, d} * 11'd6) - {3'd0, b - g};
    end else if (g == mx) begin
      hn = {2'd0, d, 1'b0} + {3'd0, b} - {3'd0, r};
    end else begin
      hn = {1'b0, d, 2'd0} + {3'd0, r} - {3'd0, g};
    end
  end

  // Value is mx * 65536 / 255 rounded to nearest, which is mx * 257 plus one
  // when the top bit of mx is set.
  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= mx; d_r <= d; hnum_r <= hn;
      px_r[0] <= in_pixel_in; gray_r[0] <= (d == 8'd0);
      v_r[0] <= {9'd0, mx} * 17'd257 + {16'd0, mx[7]};
      for (int i = 1; i < 5; i++) begin
        px_r[i] <= px_r[i-1]; gray_r[i] <= gray_r[i-1]; v_r[i] <= v_r[i-1];
      end
    end
  end

  // Stages 1-3: saturation and hue divides run side by side. The hue divides
  // by d here and by six in stage 4, which gives the same floor as dividing
  // by 6d at once.
  logic [18:0] s_q, h_q;
  hsvm_div u_sdiv (.clk(clk), .en(en),
    .num({3'd0, d_r, 16'd0} + {20'd0, mx_r[7:1]}),
    .den(mx_r), .quo(s_q));
  hsvm_div u_hdiv (.clk(clk), .en(en),
    .num({hnum_r, 16'd0} + {16'd0, 11'({3'd0, d_r} * 11'd3)}),
    .den(d_r), .quo(h_q));

  // Stage 4: hue quotient times the reciprocal of six.
  always_ff @(posedge clk) begin
    if (en) begin
      s4_r <= s_q[16:0];
      h6_r <= {20'd0, h_q} * {19'd0, hsvm_pkg::Div6Mul};
    end
  end

  // Stage 5: wrap, compare and select.
  logic [16:0] s_fin, h_full, vv;
  logic [15:0] h_fin;
  logic mk;
  always_comb begin
    s_fin = (v_r[4] == 17'd0) ? 17'd0 : s4_r;
    h_full = gray_r[4] ? 17'd0 : h6_r[38:22];
    h_fin = h_full[15:0];
    vv = v_r[4];
    mk = hue_low_r <= {1'b0, h_fin} && {1'b0, h_fin} <= hue_high_r &&
         sat_low_r <= s_fin && s_fin <= sat_high_r &&
         val_low_r <= vv && vv <= val_high_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxo_r <= mk ? hsvm_pkg::MarkColor : px_r[4];
      mk_r <= mk; h_r <= h_fin; s_r <= s_fin; vo_r <= vv;
    end
  end

  assign out_valid = vld_r[5];
  assign out_pixel_out = pxo_r;
  assign out_marked = mk_r;
  assign out_hue = h_r;
  assign out_saturation = s_r;
  assign out_brightness = vo_r;

  a_mark_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_marked |-> out_pixel_out == hsvm_pkg::MarkColor) else $error("mark");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out)) else $error("hold");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("ready");
endmodule
`default_nettype wire

@@ test/hsvm_checker.sv @@
`default_nettype none
// Checker for the HSV range pixel marker. It keeps its own copy of the six
// bounds, predicts every result from each accepted pixel and compares the
// results in order.
module hsvm_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [31:0] in_pixel_in,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] out_pixel_out,
  input  wire logic        out_marked,
  input  wire logic [15:0] out_hue,
  input  wire logic [16:0] out_saturation,
  input  wire logic [16:0] out_brightness,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data,
  output int               fail_count,
  output int               pending_count
);

  typedef struct packed {
    logic [31:0] pixel;
    logic        marked;
    logic [15:0] hue;
    logic [16:0] sat;
    logic [16:0] val;
  } mask_result_t;

  logic [16:0] bound [6];
  mask_result_t pending_q [$];

  function automatic mask_result_t mask_pixel(input logic [31:0] px);
    mask_result_t res;
    longint unsigned r, g, b, mx, mn, d, h, s, v, one;
    longint num;
    logic mark;
    one = 64'd1 << hsvm_pkg::FracBits;
    r = px[7:0];
    g = px[15:8];
    b = px[23:16];
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    v = (mx * one + 127) / 255;
    s = (mx == 0) ? 0 : (d * one + mx / 2) / mx;
    if (d == 0) begin
      h = 0;
    end else begin
      // Red wins ties for the largest channel, then green.
      if (r == mx) num = longint'(g) - longint'(b);
      else if (g == mx) num = 2 * longint'(d) + longint'(b) - longint'(r);
      else num = 4 * longint'(d) + longint'(r) - longint'(g);
      if (num < 0) num += 6 * longint'(d);
      h = (longint'(num) * one + 3 * d) / (6 * d);
      if (h >= one) h -= one;
    end
    mark = bound[hsvm_pkg::RegHueLow] <= h && h <= bound[hsvm_pkg::RegHueHigh] &&
           bound[hsvm_pkg::RegSatLow] <= s && s <= bound[hsvm_pkg::RegSatHigh] &&
           bound[hsvm_pkg::RegValLow] <= v && v <= bound[hsvm_pkg::RegValHigh];
    res.pixel = mark ? hsvm_pkg::MarkColor : px;
    res.marked = mark;
    res.hue = h[15:0];
    res.sat = s[16:0];
    res.val = v[16:0];
    return res;
  endfunction

  assign pending_count = pending_q.size();

  always @(posedge clk) begin
    mask_result_t want;
    if (!rst_n) begin
      bound[hsvm_pkg::RegHueLow] <= hsvm_pkg::One;
      bound[hsvm_pkg::RegSatLow] <= hsvm_pkg::One;
      bound[hsvm_pkg::RegValLow] <= hsvm_pkg::One;
      bound[hsvm_pkg::RegHueHigh] <= '0;
      bound[hsvm_pkg::RegSatHigh] <= '0;
      bound[hsvm_pkg::RegValHigh] <= '0;
      pending_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we && cfg_index <= hsvm_pkg::RegValHigh) bound[cfg_index] <= cfg_data;
      if (in_valid && in_ready) pending_q.push_back(mask_pixel(in_pixel_in));
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          $error("result with no pixel waiting: %h", out_pixel_out);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_q.pop_front();
          if (want.pixel !== out_pixel_out) begin
            $error("pixel_out expected %h got %h", want.pixel, out_pixel_out);
            fail_count <= fail_count + 1;
          end
          if (want.marked !== out_marked) begin
            $error("marked expected %b got %b", want.marked, out_marked);
            fail_count <= fail_count + 1;
          end
          if (want.hue !== out_hue) begin
            $error("hue expected %h got %h", want.hue, out_hue);
            fail_count <= fail_count + 1;
          end
          if (want.sat !== out_saturation) begin
            $error("saturation expected %h got %h", want.sat, out_saturation);
            fail_count <= fail_count + 1;
          end
          if (want.val !== out_brightness) begin
            $error("brightness expected %h got %h", want.val, out_brightness);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ test/tb_hsv_range_pixel_mask.sv @@
`default_nettype none
// Top of the testbench. It resets the block, writes the bounds between
// phases and feeds pixels; the checker beside the block checks every result.
module tb_hsv_range_pixel_mask;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_pixel_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_pixel_out;
  logic        out_marked;
  logic [15:0] out_hue;
  logic [16:0] out_saturation;
  logic [16:0] out_brightness;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  // The receiver process watches this to hold off for a long stretch.
  logic        hold_off = 1'b0;
  logic        stalls_on = 1'b1;

  always #4 clk = ~clk;

  hsv_range_pixel_mask u_top (.*);

  hsvm_checker u_chk (.*);

  // The run ends on a timeout if the block stops moving.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver draws a wait for every result while stalls are on, and once
  // holds off long enough for the pipeline to fill and back up into the input.
  initial begin : receiver
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = stalls_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
    end
  end

  // Offers one pixel, after a random gap when idle is set, and waits until it is accepted.
  task automatic send_pixel(input logic [31:0] px, input bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_in <= px;
    @(posedge clk iff in_ready);
  endtask

  // Waits until every result has come, then lets the pipeline run dry.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_bounds(input logic [16:0] hl, input logic [16:0] hh,
                              input logic [16:0] sl, input logic [16:0] sh,
                              input logic [16:0] vl, input logic [16:0] vh);
    logic [16:0] vals [6];
    vals = '{hl, hh, sl, sh, vl, vh};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    // An index past the last register must be ignored by the block.
    cfg_index <= 3'd7;
    cfg_data <= '0;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random pixel, biased toward grays, saturated primaries and ties so that
  // every sector and every rounding corner is reached.
  function automatic logic [31:0] random_pixel();
    logic [7:0] a, b, c;
    a = 8'($urandom);
    b = 8'($urandom);
    c = 8'($urandom);
    case ($urandom_range(0, 7))
      0: return {8'($urandom), a, a, a};
      1: return {8'($urandom), b, a, a};
      2: return {8'($urandom), a, b, a};
      3: return {8'($urandom), 8'($urandom_range(0, 1) * 255),
                 8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255)};
      default: return {8'($urandom), c, b, a};
    endcase
  endfunction

  // Random bounds, each low bound at or below its high bound.
  task automatic random_bounds();
    logic [16:0] h0, h1, s0, s1, v0, v1;
    h0 = 17'($urandom_range(0, 65535));
    h1 = 17'($urandom_range(h0, 65536));
    s0 = 17'($urandom_range(0, 32768));
    s1 = 17'($urandom_range(s0, 65536));
    v0 = 17'($urandom_range(0, 32768));
    v1 = 17'($urandom_range(v0, 65536));
    write_bounds(h0, h1, s0, s1, v0, v1);
  endtask

  initial begin : stimulus
    logic [31:0] directed [] = '{
      32'h00000000, 32'hFFFFFFFF, 32'h000000FF, 32'h0000FF00, 32'h00FF0000,
      32'hAA808080, 32'h0000FFFF, 32'h00FFFF00, 32'h00FF00FF, 32'h00FF00FE,
      32'h55FE00FF, 32'h00010000, 32'h00000001, 32'h00FFFEFF, 32'h00000100,
      32'h00FEFFFF, 32'h12345678, 32'h00010203, 32'h80040201};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset bounds mark nothing.
    foreach (directed[i]) send_pixel(directed[i], 1'b0);
    wait_idle();

    // Widest bounds mark every pixel.
    write_bounds(17'd0, 17'h1FFFF, 17'd0, 17'h1FFFF, 17'd0, 17'h1FFFF);
    foreach (directed[i]) send_pixel(directed[i], 1'b1);
    wait_idle();

    // Exact extremes: pure red with full saturation and value.
    write_bounds(17'd0, 17'd0, hsvm_pkg::One, hsvm_pkg::One, hsvm_pkg::One,
                 hsvm_pkg::One);
    foreach (directed[i]) send_pixel(directed[i], 1'b0);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      random_bounds();
      stalls_on = (phase != 2);
      if (phase == 3) hold_off = 1'b1;
      for (int n = 0; n < 60; n++) send_pixel(random_pixel(), phase != 1);
      // The sender pauses here until every result has come.
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
